[sv/sitdt_pkg.sv]
package sitdt_pkg;

	localparam int DEFAULT_VALUE_WIDTH = 32;

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic drop;
		logic sel_sign;
	} cmd_t;

	typedef struct packed {
		logic conv_done;
		logic lead_zero;
		logic last_digit;
		logic negative;
	} status_t;

endpackage

[sv/sitdt_if.sv]
interface sitdt_value_if #(
	parameter int VALUE_WIDTH = sitdt_pkg::DEFAULT_VALUE_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface sitdt_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       last_char;

	modport source (output valid, output text_char, output last_char, input ready);
	modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

[sv/sitdt_ctrl.sv]
module sitdt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_last,
	input  sitdt_pkg::status_t  status,
	output sitdt_pkg::cmd_t     cmd
);

	sitdt_pkg::state_t state_q;
	sitdt_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sitdt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		out_last  = 1'b0;
		case (state_q)
			sitdt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sitdt_pkg::ST_CONV;
				end
			end
			sitdt_pkg::ST_CONV: begin
				if (status.conv_done) begin
					state_d = sitdt_pkg::ST_SKIP;
				end else begin
					cmd.shift = 1'b1;
				end
			end
			sitdt_pkg::ST_SKIP: begin
				if (status.lead_zero) begin
					cmd.drop = 1'b1;
				end else if (status.negative) begin
					state_d = sitdt_pkg::ST_SIGN;
				end else begin
					state_d = sitdt_pkg::ST_EMIT;
				end
			end
			sitdt_pkg::ST_SIGN: begin
				out_valid    = 1'b1;
				cmd.sel_sign = 1'b1;
				if (out_ready) begin
					state_d = sitdt_pkg::ST_EMIT;
				end
			end
			sitdt_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				out_last  = status.last_digit;
				if (out_ready) begin
					if (status.last_digit) begin
						state_d = sitdt_pkg::ST_IDLE;
					end else begin
						cmd.drop = 1'b1;
					end
				end
			end
			default: begin
				state_d = sitdt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[sv/sitdt_dp.sv]
module sitdt_dp #(
	parameter int VALUE_WIDTH = sitdt_pkg::DEFAULT_VALUE_WIDTH,
	parameter int NUM_DIGITS  = 10
) (
	input  logic                          clk,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  sitdt_pkg::cmd_t               cmd,
	output sitdt_pkg::status_t            status,
	output logic [7:0]                    text_char
);

	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int REM_W = $clog2(NUM_DIGITS + 1);
	localparam int BCD_W = 4 * NUM_DIGITS;

	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] mag;
	logic [VALUE_WIDTH-1:0] bin_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       adj;
	logic [CNT_W-1:0]       bit_cnt_q;
	logic [REM_W-1:0]       rem_q;
	logic                   neg_q;
	logic [3:0]             top_digit;

	assign raw       = value;
	assign mag       = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
	assign top_digit = bcd_q[BCD_W-1 -: 4];

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] inside {[4'd5:4'd9]}) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q     <= mag;
			bcd_q     <= '0;
			neg_q     <= raw[VALUE_WIDTH-1];
			bit_cnt_q <= CNT_W'(VALUE_WIDTH);
			rem_q     <= REM_W'(NUM_DIGITS);
		end else if (cmd.shift) begin
			bcd_q     <= {adj[BCD_W-2:0], bin_q[VALUE_WIDTH-1]};
			bin_q     <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
			bit_cnt_q <= bit_cnt_q - 1'b1;
		end else if (cmd.drop) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
			rem_q <= rem_q - 1'b1;
		end
	end

	assign status.conv_done  = (bit_cnt_q == '0);
	assign status.lead_zero  = (top_digit == 4'd0) && (rem_q > REM_W'(1));
	assign status.last_digit = (rem_q == REM_W'(1));
	assign status.negative   = neg_q;

	assign text_char = cmd.sel_sign ? sitdt_pkg::CHAR_MINUS
	                                : (sitdt_pkg::CHAR_ZERO + {4'd0, top_digit});

endmodule

[sv/signed_int_to_decimal_text.sv]
// Converts one signed word to decimal ASCII, one character per output word, sign first.
// The word is loaded, converted by the bit-serial shift-add-3 binary-to-BCD loop, and then
// leading zero digits are dropped one per cycle before the first character is sent; the
// characters then follow one per cycle while the receiver is ready. A new word is taken only
// in idle, after the last character of the previous word has been accepted.
// Reset: asynchronous, active low, returns the controller to idle; no item is held.
module signed_int_to_decimal_text #(
	parameter int VALUE_WIDTH = sitdt_pkg::DEFAULT_VALUE_WIDTH
) (
	input logic            clk,
	input logic            arst_n,
	sitdt_value_if.sink    number,
	sitdt_char_if.source   text
);

	localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;

	sitdt_pkg::cmd_t    cmd;
	sitdt_pkg::status_t status;

	sitdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (number.valid),
		.in_ready  (number.ready),
		.out_valid (text.valid),
		.out_ready (text.ready),
		.out_last  (text.last_char),
		.status    (status),
		.cmd       (cmd)
	);

	sitdt_dp #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.NUM_DIGITS  (NUM_DIGITS)
	) u_dp (
		.clk       (clk),
		.value     (number.value),
		.cmd       (cmd),
		.status    (status),
		.text_char (text.text_char)
	);

endmodule

[tb/decimal_text_check.sv]
`timescale 1ns / 100ps

module decimal_text_check #(
	parameter int VALUE_WIDTH = sitdt_pkg::DEFAULT_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          number_valid,
	input  logic                          number_ready,
	input  logic signed [VALUE_WIDTH-1:0] number_value,
	input  logic                          text_valid,
	input  logic                          text_ready,
	input  logic [7:0]                    text_char,
	input  logic                          last_char,
	output int                            fails,
	output int                            chars_pending
);

	localparam int RADIX = 10;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_word_t;

	text_word_t pending_chars[$];
	int         mismatches = 0;
	int         words_seen = 0;

	assign fails         = mismatches;
	assign chars_pending = pending_chars.size();

	task automatic report_mismatch(input string what);
		$display("%0t ns: text word %0d: %s", $time, words_seen, what);
		mismatches++;
	endtask

	function automatic void queue_decimal_text(input logic signed [VALUE_WIDTH-1:0] v);
		logic [VALUE_WIDTH-1:0] mag;
		logic [7:0]             digits[$];
		mag = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
		do begin
			digits.push_front(sitdt_pkg::CHAR_ZERO + 8'(mag % RADIX));
			mag = mag / RADIX;
		end while (mag != 0);
		if (v[VALUE_WIDTH-1])
			pending_chars.push_back('{ch: sitdt_pkg::CHAR_MINUS, last: 1'b0});
		foreach (digits[i])
			pending_chars.push_back('{ch: digits[i], last: (i == digits.size() - 1)});
	endfunction

	always @(posedge clk) begin
		text_word_t want;
		if (arst_n) begin
			if (number_valid && number_ready)
				queue_decimal_text(number_value);
			if (text_valid && text_ready) begin
				if (pending_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected char %0d last %0b",
						text_char, last_char));
				end else begin
					want = pending_chars.pop_front();
					if (text_char !== want.ch)
						report_mismatch($sformatf("char %0d, want %0d", text_char, want.ch));
					if (last_char !== want.last)
						report_mismatch($sformatf("last %b, want %b", last_char, want.last));
				end
				words_seen++;
			end
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

	localparam int VW         = sitdt_pkg::DEFAULT_VALUE_WIDTH;
	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD  = 400;
	localparam int DRAIN      = 60;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	logic hold_req      = 1'b0;
	logic hold_taken    = 1'b0;
	int   hold_left     = 0;
	int   idle_cycles   = 0;
	int   fails;
	int   chars_pending;

	sitdt_value_if #(.VALUE_WIDTH(VW)) number_ch ();
	sitdt_char_if text_ch ();

	signed_int_to_decimal_text #(.VALUE_WIDTH(VW)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.number (number_ch.sink),
		.text   (text_ch.source)
	);

	decimal_text_check #(.VALUE_WIDTH(VW)) checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.number_valid  (number_ch.valid),
		.number_ready  (number_ch.ready),
		.number_value  (number_ch.value),
		.text_valid    (text_ch.valid),
		.text_ready    (text_ch.ready),
		.text_char     (text_ch.text_char),
		.last_char     (text_ch.last_char),
		.fails         (fails),
		.chars_pending (chars_pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n) begin
			text_ch.ready <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_taken    <= 1'b1;
			hold_left     <= LONG_HOLD;
			text_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			text_ch.ready <= 1'b0;
		end else begin
			text_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((number_ch.valid && number_ch.ready) || (text_ch.valid && text_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("signed_int_to_decimal_text verification failed");
				$finish;
			end
		end
	end

	function automatic longint pow10(input int k);
		longint p;
		p = 1;
		repeat (k) p = p * 10;
		return p;
	endfunction

	function automatic logic signed [VW-1:0] random_value();
		longint mag;
		int     k;
		k = $urandom_range(9);
		case ($urandom_range(5))
			0, 1: return VW'($urandom);
			2: mag = $urandom_range(99);
			3: mag = pow10(k) + $urandom_range(2) - 1;
			4: mag = 64'h7FFF_FFFF - $urandom_range(3);
			default: mag = longint'($urandom) % pow10(k + 1);
		endcase
		if ($urandom_range(1))
			mag = -mag - $urandom_range(1);
		return VW'(mag);
	endfunction

	task automatic put_value(input logic signed [VW-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			number_ch.valid <= 1'b0;
			@(posedge clk);
		end
		number_ch.valid <= 1'b1;
		number_ch.value <= v;
		do @(posedge clk); while (!number_ch.ready);
	endtask

	task automatic put_random(input int n);
		repeat (n) put_value(random_value());
	endtask

	initial begin
		static int directed[] = '{0, 1, -1, 5, 9, 10, -10, 99, -100, 2147483647,
			32'sh8000_0000, -2147483647, 1000000000, 999999999, -999999999, -1000000000,
			1234567890, -1234567890, 32'h5555_5555, 32'hAAAA_AAAA, 2147483640};
		number_ch.valid = 1'b0;
		number_ch.value = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct <= 15;
		recv_idle_pct <= 56;
		foreach (directed[i])
			put_value(VW'(directed[i]));
		put_random(70);

		send_idle_pct <= 56;
		recv_idle_pct <= 15;
		put_random(85);

		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		hold_req      <= 1'b1;
		put_random(85);

		number_ch.valid <= 1'b0;
		do @(negedge clk); while (chars_pending != 0);
		repeat (DRAIN) @(posedge clk);

		if (fails == 0)
			$display("signed_int_to_decimal_text verification clean");
		else
			$display("signed_int_to_decimal_text verification failed");
		$finish;
	end

endmodule

[signed_int_to_decimal_text.f]
sv/sitdt_pkg.sv
sv/sitdt_if.sv
sv/sitdt_ctrl.sv
sv/sitdt_dp.sv
sv/signed_int_to_decimal_text.sv
tb/decimal_text_check.sv
tb/tb.sv
